// ----- rtl/core/gclu_pkg.sv -----
`default_nettype none
package gclu_pkg;

   // default line buffer size, one entry kept free as in the original firmware
   localparam int LINE_BYTES_DEF = 96;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_EXEC
   } state_type;

   // status codes
   localparam logic [2:0] STS_OK       = 3'd0;
   localparam logic [2:0] STS_HELLO    = 3'd1;
   localparam logic [2:0] STS_PINS     = 3'd2;
   localparam logic [2:0] STS_BAD_PIN  = 3'd3;
   localparam logic [2:0] STS_RESERVED = 3'd4;
   localparam logic [2:0] STS_BAD_MODE = 3'd5;
   localparam logic [2:0] STS_BAD_VAL  = 3'd6;
   localparam logic [2:0] STS_BAD_CMD  = 3'd7;

   // mode nibble values
   localparam logic [3:0] MODE_OUT    = 4'h2;
   localparam logic [3:0] MODE_IN     = 4'h4;
   localparam logic [3:0] MODE_ANALOG = 4'h0;

   // characters
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_NUL   = 8'd0;

   // keyword list: commands first, then argument words
   localparam int W_HELLO  = 0;
   localparam int W_PINS   = 1;
   localparam int W_MODE   = 2;
   localparam int W_WRITE  = 3;
   localparam int W_READ   = 4;
   localparam int W_TOGGLE = 5;
   localparam int W_OUT    = 6;
   localparam int W_IN     = 7;
   localparam int W_ANALOG = 8;
   localparam int W_ONE    = 9;
   localparam int W_HIGH   = 10;
   localparam int NUM_WORDS = 11;

   // characters packed first letter in the low byte
   localparam logic [63:0] WORD_CHARS [NUM_WORDS] = '{
      64'("OLLEH"), 64'("SNIP"), 64'("EDOM"), 64'("ETIRW"), 64'("DAER"),
      64'("ELGGOT"), 64'("TUO"), 64'("NI"), 64'("GOLANA"), 64'("1"), 64'("HGIH")
   };
   localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{
      3'd5, 3'd4, 3'd4, 3'd5, 3'd4, 3'd6, 3'd3, 3'd2, 3'd6, 3'd1, 3'd4
   };

   // reset state
   localparam logic [63:0] MODES_A_RST = 64'h4444_4444_4444_4444;
   localparam logic [63:0] MODES_B_RST = 64'h4444_4444_4A44_4444;
   localparam logic [63:0] MODES_C_RST = 64'h4424_4444_4444_4444;
   localparam logic [47:0] LATCH_RST   = 48'h2000_0000_0000;

   typedef struct packed {
      logic take;
      logic close;
      logic exec;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_term;
      logic out_free;
   } ctl_sts_type;

endpackage
`default_nettype wire

// ----- rtl/core/gclu_if.sv -----
`default_nettype none
interface gclu_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_byte;
   logic [47:0] pin_levels;
   modport source (output valid, rx_byte, pin_levels, input ready);
   modport sink (input valid, rx_byte, pin_levels, output ready);
endinterface

interface gclu_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        read_level;
   logic [63:0] port_a_modes;
   logic [63:0] port_b_modes;
   logic [63:0] port_c_modes;
   logic [47:0] output_latches;
   modport source (output valid, status, read_level, port_a_modes, port_b_modes,
                   port_c_modes, output_latches, input ready);
   modport sink (input valid, status, read_level, port_a_modes, port_b_modes,
                 port_c_modes, output_latches, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/gclu_ctrl.sv -----
`default_nettype none
module gclu_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  gclu_pkg::ctl_sts_type    sts,
   output gclu_pkg::ctl_cmd_type    cmd
);
   import gclu_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.is_term) state_in = ST_CLOSE;
         end
         ST_CLOSE: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_CLOSE: begin
            cmd.close = 1'b1;
         end
         ST_EXEC: begin
            cmd.exec = sts.out_free;
         end
         default: ;
      endcase
   end

   // line end runs close then execute, never during byte intake
   a_close_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.close |=> (state_ff == ST_EXEC) && !req_ready)
      else $error("close not followed by execute");
endmodule
`default_nettype wire

// ----- rtl/core/gclu_dp.sv -----
`default_nettype none
module gclu_dp #(
   parameter int LINE_BYTES = gclu_pkg::LINE_BYTES_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  gclu_pkg::ctl_cmd_type    cmd,
   output gclu_pkg::ctl_sts_type    sts,
   gclu_req_if.sink                 req_if,
   gclu_rsp_if.source               rsp_if
);
   import gclu_pkg::*;

   localparam int CW = $clog2(LINE_BYTES);
   localparam logic [CW-1:0] CNT_MAX = CW'(LINE_BYTES - 1);

   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   stop_ff, stop_in;
   logic                   intok_ff, intok_in;
   logic [1:0]             tokcnt_ff, tokcnt_in;
   logic [2:0]             pos_ff, pos_in;
   logic [NUM_WORDS-1:0]   flags_ff, flags_in;
   logic                   pok_ff, pok_in;
   logic [1:0]             port_ff, port_in;
   logic [4:0]             num_ff, num_in;
   logic [5:0]             cmdres_ff, cmdres_in;
   logic                   pgood_ff, pgood_in;
   logic [4:0]             argres_ff, argres_in;
   logic                   arghave_ff, arghave_in;
   logic [47:0]            lvl_ff, lvl_in;
   logic [63:0]            modes_ff [3];
   logic [63:0]            modes_in [3];
   logic [47:0]            latch_ff, latch_in;
   logic                   rvalid_ff, rvalid_in;
   logic [2:0]             status_ff, status_in;
   logic                   rlvl_ff, rlvl_in;

   logic [7:0]             c;
   logic [2:0]             pos_eff;
   logic [NUM_WORDS-1:0]   hit, lenm;
   logic [7:0]             prod;
   logic                   do_close;
   logic [5:0]             bit_idx;
   logic                   reserved;

   assign c           = req_if.rx_byte;
   assign sts.is_term = (c == CH_CR) || (c == CH_LF);
   assign sts.out_free = !rvalid_ff || rsp_if.ready;

   // keyword character compare at current token position
   always_comb begin
      pos_eff = intok_ff ? pos_ff : 3'd0;
      for (int w = 0; w < NUM_WORDS; w++) begin
         hit[w]  = (pos_eff < WORD_LEN[w]) && (c == WORD_CHARS[w][{pos_eff, 3'b000} +: 8]);
         lenm[w] = flags_ff[w] && (pos_ff == WORD_LEN[w]);
      end
      prod = 8'({3'b000, num_ff} * 8'd10) + 8'(c - "0");
   end

   assign bit_idx  = {port_ff, num_ff[3:0]};
   assign reserved = ((port_ff == 2'd0) && (num_ff[3:0] == 4'd13 || num_ff[3:0] == 4'd14)) ||
                     ((port_ff == 2'd1) && (num_ff[3:0] == 4'd6 || num_ff[3:0] == 4'd7));

   always_comb begin
      cnt_in     = cnt_ff;
      stop_in    = stop_ff;
      intok_in   = intok_ff;
      tokcnt_in  = tokcnt_ff;
      pos_in     = pos_ff;
      flags_in   = flags_ff;
      pok_in     = pok_ff;
      port_in    = port_ff;
      num_in     = num_ff;
      cmdres_in  = cmdres_ff;
      pgood_in   = pgood_ff;
      argres_in  = argres_ff;
      arghave_in = arghave_ff;
      lvl_in     = lvl_ff;
      modes_in   = modes_ff;
      latch_in   = latch_ff;
      rvalid_in  = rvalid_ff && !rsp_if.ready;
      status_in  = status_ff;
      rlvl_in    = rlvl_ff;
      do_close   = cmd.close && intok_ff;

      // byte intake
      if (cmd.take) begin
         lvl_in = req_if.pin_levels;
         if (!sts.is_term && (cnt_ff < CNT_MAX)) begin
            cnt_in = cnt_ff + 1'b1;
            if (!stop_ff) begin
               if (c == CH_NUL) begin
                  stop_in = 1'b1;
               end else if (c == CH_SPACE) begin
                  do_close = intok_ff;
               end else begin
                  intok_in = 1'b1;
                  flags_in = (intok_ff ? flags_ff : '1) & hit;
                  pos_in   = (pos_eff == 3'd7) ? 3'd7 : pos_eff + 3'd1;
                  // pin decode only on the second token
                  if (tokcnt_ff == 2'd1) begin
                     if (pos_eff == 3'd0) begin
                        pok_in = (c == "P");
                        num_in = 5'd0;
                     end else if (pos_eff == 3'd1) begin
                        pok_in  = pok_ff && (c >= "A") && (c <= "C");
                        port_in = c[1:0] - 2'd1;
                     end else begin
                        pok_in = pok_ff && (c >= "0") && (c <= "9");
                        num_in = (prod > 8'd15) ? 5'd16 : prod[4:0];
                     end
                  end
               end
            end
         end
      end

      // token end
      if (do_close) begin
         intok_in = 1'b0;
         if (tokcnt_ff != 2'd3) tokcnt_in = tokcnt_ff + 2'd1;
         case (tokcnt_ff)
            2'd0: cmdres_in = lenm[W_TOGGLE:W_HELLO];
            2'd1: pgood_in  = pok_ff && (pos_ff >= 3'd3) && !num_ff[4];
            2'd2: begin
               argres_in  = lenm[W_HIGH:W_OUT];
               arghave_in = 1'b1;
            end
            default: ;
         endcase
      end

      // command execution
      if (cmd.exec) begin
         cnt_in     = '0;
         stop_in    = 1'b0;
         intok_in   = 1'b0;
         tokcnt_in  = 2'd0;
         cmdres_in  = '0;
         pgood_in   = 1'b0;
         argres_in  = '0;
         arghave_in = 1'b0;
         if (tokcnt_ff != 2'd0) begin
            rvalid_in = 1'b1;
            rlvl_in   = 1'b0;
            if (cmdres_ff[W_HELLO]) begin
               status_in = STS_HELLO;
            end else if (cmdres_ff[W_PINS]) begin
               status_in = STS_PINS;
            end else if (!pgood_ff) begin
               status_in = STS_BAD_PIN;
            end else if (reserved) begin
               status_in = STS_RESERVED;
            end else if (cmdres_ff[W_MODE]) begin
               status_in = STS_OK;
               if (argres_ff[W_OUT-W_OUT]) begin
                  modes_in[port_ff][{num_ff[3:0], 2'b00} +: 4] = MODE_OUT;
               end else if (argres_ff[W_IN-W_OUT]) begin
                  modes_in[port_ff][{num_ff[3:0], 2'b00} +: 4] = MODE_IN;
               end else if (argres_ff[W_ANALOG-W_OUT]) begin
                  modes_in[port_ff][{num_ff[3:0], 2'b00} +: 4] = MODE_ANALOG;
               end else begin
                  status_in = STS_BAD_MODE;
               end
            end else if (cmdres_ff[W_WRITE]) begin
               if (!arghave_ff) begin
                  status_in = STS_BAD_VAL;
               end else begin
                  status_in         = STS_OK;
                  latch_in[bit_idx] = argres_ff[W_ONE-W_OUT] || argres_ff[W_HIGH-W_OUT];
               end
            end else if (cmdres_ff[W_READ]) begin
               status_in = STS_OK;
               rlvl_in   = lvl_ff[bit_idx];
            end else if (cmdres_ff[W_TOGGLE]) begin
               status_in         = STS_OK;
               latch_in[bit_idx] = !lvl_ff[bit_idx];
            end else begin
               status_in = STS_BAD_CMD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         stop_ff     <= 1'b0;
         intok_ff    <= 1'b0;
         tokcnt_ff   <= 2'd0;
         cmdres_ff   <= '0;
         pgood_ff    <= 1'b0;
         argres_ff   <= '0;
         arghave_ff  <= 1'b0;
         rvalid_ff   <= 1'b0;
         modes_ff[0] <= MODES_A_RST;
         modes_ff[1] <= MODES_B_RST;
         modes_ff[2] <= MODES_C_RST;
         latch_ff    <= LATCH_RST;
      end else begin
         cnt_ff      <= cnt_in;
         stop_ff     <= stop_in;
         intok_ff    <= intok_in;
         tokcnt_ff   <= tokcnt_in;
         cmdres_ff   <= cmdres_in;
         pgood_ff    <= pgood_in;
         argres_ff   <= argres_in;
         arghave_ff  <= arghave_in;
         rvalid_ff   <= rvalid_in;
         modes_ff    <= modes_in;
         latch_ff    <= latch_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      flags_ff  <= flags_in;
      pok_ff    <= pok_in;
      port_ff   <= port_in;
      num_ff    <= num_in;
      lvl_ff    <= lvl_in;
      status_ff <= status_in;
      rlvl_ff   <= rlvl_in;
   end

   assign rsp_if.valid          = rvalid_ff;
   assign rsp_if.status         = status_ff;
   assign rsp_if.read_level     = rlvl_ff;
   assign rsp_if.port_a_modes   = modes_ff[0];
   assign rsp_if.port_b_modes   = modes_ff[1];
   assign rsp_if.port_c_modes   = modes_ff[2];
   assign rsp_if.output_latches = latch_ff;

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("line count past buffer size");
   a_exec_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> (cnt_ff == '0) && (tokcnt_ff == 2'd0) && !intok_ff)
      else $error("line state not cleared after execute");
   a_exec_free: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> (!rvalid_ff || rsp_if.ready))
      else $error("execute while result pending");
   a_reserved_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $stable(modes_ff[0][59:52]) && $stable(latch_ff[14:13])
                        && $stable(modes_ff[1][31:24]))
      else $error("reserved pin changed");
endmodule
`default_nettype wire

// ----- rtl/core/gpio_command_line_interpreter_unit.sv -----
`default_nettype none
// channel   dir   handshake        beat payload
// req_if    in    valid/ready      rx_byte[7:0], pin_levels[47:0]
// rsp_if    out   valid/ready      status, read_level, port_a/b/c_modes, output_latches
//
// A printable byte is accepted in the idle state and is tokenized as it arrives.
// CR/LF goes through accept, close token and execute in turn; execute waits
// while the previous result beat has not been taken.
// Bytes are still accepted while a result beat waits in the output register.
// Synchronous active-high reset; restores pin modes and latches, no clearing pass.
module gpio_command_line_interpreter_unit #(
   parameter int LINE_BYTES = gclu_pkg::LINE_BYTES_DEF
) (
   input  wire          clock,
   input  wire          reset,
   gclu_req_if.sink     req_if,
   gclu_rsp_if.source   rsp_if
);
   import gclu_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   gclu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gclu_dp #(.LINE_BYTES(LINE_BYTES)) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sts    (sts),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );
endmodule
`default_nettype wire
